FILE: rtl/core/ple_pkg.sv
// ple_pkg: command codes, status codes and cell control modes for the
// positional list engine. Depends on nothing; used by ple_cell and the top level.
package ple_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 5;
	localparam int DEF_CAPACITY = 32;

	typedef enum logic [2:0] {
		OP_PUSH       = 3'd0,
		OP_INS_BEFORE = 3'd1,
		OP_INS_AFTER  = 3'd2,
		OP_REMOVE     = 3'd3,
		OP_READ       = 3'd4,
		OP_CLEAR      = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} cell_mode_t;

endpackage

FILE: rtl/core/ple_cell.sv
// ple_cell: one list entry; loads the new item, takes from its left or right
// neighbour, or holds. Depends on ple_pkg.
module ple_cell
	import ple_pkg::*;
#(
	parameter int K     = 0,
	parameter int CNT_W = 6
) (
	input  logic                     clk,
	input  cell_mode_t               mode,
	input  logic [CNT_W-1:0]         at,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic signed [DATA_W-1:0] left_d,
	input  logic signed [DATA_W-1:0] right_d,
	output logic signed [DATA_W-1:0] q
);

	logic signed [DATA_W-1:0] entry_q;
	logic                     at_eq;
	logic                     at_lt;

	assign at_eq = (K == int'(at));
	assign at_lt = (K > int'(at));
	assign q     = entry_q;

	always_ff @(posedge clk) begin
		unique case (mode)
			CELL_INSERT: begin
				if (at_eq) begin
					entry_q <= item_value;
				end else if (at_lt) begin
					entry_q <= left_d;
				end
			end
			CELL_REMOVE: begin
				if (at_eq || at_lt) begin
					entry_q <= right_d;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

FILE: rtl/core/positional_list_engine.sv
// positional_list_engine: ordered list of signed values held in a row of
// ple_cell entries, with command decode, count and result registers.
// Depends on ple_pkg and ple_cell.
//
//  channel   direction  handshake            payload
//  command   in         start & !busy        op, position, item_value
//  result    out        done (one cycle)     read_value, list_length, status
//
// One item per cycle: on an insert or remove, the cells at and after the
// target position shift or load in the cycle the item is taken; the rest hold.
// The result appears on the cycle after acceptance, marked by done.
// busy stays low; a new item may be taken while the last result is shown.
// Reset clears the count and the result strobe; entries are unset until written.
// The receiver cannot stall; each result is shown for one cycle only.
module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               op,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] item_value,
	output logic                     done,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_W-1:0]         list_length,
	output logic [1:0]               status
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

	logic signed [DATA_W-1:0] cell_q [CAPACITY];
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nxt;
	logic                     done_q;
	logic signed [DATA_W-1:0] read_value_q;
	status_t                  status_q;

	logic                     accept;
	logic                     full;
	logic                     pos_ok;
	logic [CMP_W-1:0]         pos_ext;
	logic [IDX_W-1:0]         rd_idx;
	cell_mode_t               mode;
	logic [CNT_W-1:0]         at;
	status_t                  st;
	logic signed [DATA_W-1:0] rd;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign pos_ext = CMP_W'(position);
	assign pos_ok  = (pos_ext < CMP_W'(count_q));
	assign rd_idx  = pos_ext[IDX_W-1:0];

	always_comb begin
		mode      = CELL_HOLD;
		at        = '0;
		st        = ST_OK;
		rd        = '0;
		count_nxt = count_q;
		if (accept) begin
			unique case (op_t'(op))
				OP_PUSH: begin
					if (full) begin
						st = ST_FULL;
					end else begin
						mode      = CELL_INSERT;
						at        = count_q;
						count_nxt = count_q + 1'b1;
					end
				end
				OP_INS_BEFORE, OP_INS_AFTER: begin
					if (full) begin
						st = ST_FULL;
					end else if (count_q == '0) begin
						mode      = CELL_INSERT;
						at        = '0;
						count_nxt = count_q + 1'b1;
					end else if (!pos_ok) begin
						st = ST_RANGE;
					end else begin
						mode      = CELL_INSERT;
						at        = (op_t'(op) == OP_INS_BEFORE) ? CNT_W'(pos_ext)
							: CNT_W'(pos_ext + 1'b1);
						count_nxt = count_q + 1'b1;
					end
				end
				OP_REMOVE: begin
					if (!pos_ok) begin
						st = ST_RANGE;
					end else begin
						mode      = CELL_REMOVE;
						at        = CNT_W'(pos_ext);
						rd        = cell_q[rd_idx];
						count_nxt = count_q - 1'b1;
					end
				end
				OP_READ: begin
					if (!pos_ok) begin
						st = ST_RANGE;
					end else begin
						rd = cell_q[rd_idx];
					end
				end
				OP_CLEAR: begin
					count_nxt = '0;
				end
				default: begin
					st = ST_OK;
				end
			endcase
		end
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;
		if (k == 0) begin : g_first
			assign left_d = item_value;
		end else begin : g_mid_l
			assign left_d = cell_q[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_d = cell_q[k];
		end else begin : g_mid_r
			assign right_d = cell_q[k+1];
		end
		ple_cell #(
			.K     (k),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.mode       (mode),
			.at         (at),
			.item_value (item_value),
			.left_d     (left_d),
			.right_d    (right_d),
			.q          (cell_q[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd;
			status_q     <= st;
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign list_length = count_q;
	assign status      = status_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count above capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted item gave no result");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count moved without an item");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL) |-> list_length == CNT_W'(CAPACITY))
		else $error("full status on a list that is not full");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_RANGE) |-> read_value == '0)
		else $error("range failure returned a value");
`endif

endmodule

FILE: bench/tb_positional_list_engine.sv
// tb_positional_list_engine: directed table then biased random commands for the
// positional list engine, checked against an in-bench list predictor.
// Depends on ple_pkg and the positional_list_engine top level.
module tb_positional_list_engine;
	import ple_pkg::*;

	localparam int CAP        = DEF_CAPACITY;
	localparam int LEN_W      = $clog2(DEF_CAPACITY + 1);
	localparam int IDLE_LIMIT = 2000;
	localparam int RAND_ITEMS = 134;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	localparam logic [DATA_W-1:0] V_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] V_MAX  = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] V_NEG1 = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		MODE_FILL  = 2'd0,
		MODE_DRAIN = 2'd1,
		MODE_MIX   = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rd;
		logic [LEN_W-1:0]         len;
		status_t                  st;
	} outcome_t;

	typedef struct {
		logic [2:0]        c_op;
		logic [POS_W-1:0]  c_pos;
		logic [DATA_W-1:0] c_val;
		bit                pin;
		logic [DATA_W-1:0] e_rd;
		logic [LEN_W-1:0]  e_len;
		status_t           e_st;
	} row_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	logic [2:0]               op         = OP_PUSH;
	logic [POS_W-1:0]         position   = '0;
	logic signed [DATA_W-1:0] item_value = '0;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] read_value;
	logic [LEN_W-1:0]         list_length;
	logic [1:0]               status;

	bit                row_pin = 1'b0;
	logic [DATA_W-1:0] row_rd  = '0;
	logic [LEN_W-1:0]  row_len = '0;
	status_t           row_st  = ST_OK;

	logic signed [DATA_W-1:0] shadow_entries [CAP];
	int                       shadow_len = 0;
	int                       hint_len   = 0;
	outcome_t                 outcomes_due [$];
	int                       err_count  = 0;
	int                       idle_cycles = 0;

	row_t plan [23] = '{
		'{OP_READ,       5'd0,  32'd0,        1'b1, 32'd0,  6'd0, ST_RANGE},
		'{OP_REMOVE,     5'd0,  32'd0,        1'b1, 32'd0,  6'd0, ST_RANGE},
		'{OP_INS_BEFORE, 5'd31, 32'd5,        1'b1, 32'd0,  6'd1, ST_OK},
		'{OP_CLEAR,      5'd0,  32'd0,        1'b1, 32'd0,  6'd0, ST_OK},
		'{OP_INS_AFTER,  5'd17, V_MIN,        1'b1, 32'd0,  6'd1, ST_OK},
		'{OP_PUSH,       5'd0,  V_MAX,        1'b1, 32'd0,  6'd2, ST_OK},
		'{OP_PUSH,       5'd31, 32'd0,        1'b1, 32'd0,  6'd3, ST_OK},
		'{OP_PUSH,       5'd9,  V_NEG1,       1'b1, 32'd0,  6'd4, ST_OK},
		'{OP_READ,       5'd0,  32'd0,        1'b1, V_MIN,  6'd4, ST_OK},
		'{OP_READ,       5'd3,  32'd0,        1'b1, V_NEG1, 6'd4, ST_OK},
		'{OP_INS_BEFORE, 5'd0,  32'h1234_5678, 1'b0, 32'd0, 6'd0, ST_OK},
		'{OP_INS_AFTER,  5'd4,  32'hA5A5_5A5A, 1'b0, 32'd0, 6'd0, ST_OK},
		'{OP_INS_BEFORE, 5'd6,  32'd1,        1'b1, 32'd0,  6'd6, ST_RANGE},
		'{OP_INS_AFTER,  5'd31, 32'd2,        1'b1, 32'd0,  6'd6, ST_RANGE},
		'{OP_READ,       5'd5,  32'd0,        1'b0, 32'd0,  6'd0, ST_OK},
		'{OP_READ,       5'd31, 32'd0,        1'b1, 32'd0,  6'd6, ST_RANGE},
		'{OP_REMOVE,     5'd0,  32'd0,        1'b0, 32'd0,  6'd0, ST_OK},
		'{OP_REMOVE,     5'd4,  32'd0,        1'b0, 32'd0,  6'd0, ST_OK},
		'{OP_REMOVE,     5'd31, 32'd0,        1'b1, 32'd0,  6'd4, ST_RANGE},
		'{OP_INS_AFTER,  5'd2,  32'h0F0F_0F0F, 1'b0, 32'd0, 6'd0, ST_OK},
		'{OP_SPARE_A,    5'd9,  32'h5555_AAAA, 1'b1, 32'd0, 6'd5, ST_OK},
		'{OP_SPARE_B,    5'd31, V_NEG1,       1'b1, 32'd0,  6'd5, ST_OK},
		'{OP_CLEAR,      5'd31, V_NEG1,       1'b1, 32'd0,  6'd0, ST_OK}
	};

	positional_list_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.position   (position),
		.item_value (item_value),
		.done       (done),
		.read_value (read_value),
		.list_length(list_length),
		.status     (status)
	);

	always #5 clk = ~clk;

	function automatic outcome_t list_apply(logic [2:0] c_op, logic [POS_W-1:0] c_pos,
			logic signed [DATA_W-1:0] c_val);
		outcome_t r;
		int       at;
		r.rd = '0;
		r.st = ST_OK;
		case (c_op)
			OP_PUSH, OP_INS_BEFORE, OP_INS_AFTER: begin
				if (shadow_len >= CAP) begin
					r.st = ST_FULL;
				end else if (c_op != OP_PUSH && shadow_len != 0 && int'(c_pos) >= shadow_len) begin
					r.st = ST_RANGE;
				end else begin
					if (c_op == OP_PUSH)
						at = shadow_len;
					else if (shadow_len == 0)
						at = 0;
					else if (c_op == OP_INS_BEFORE)
						at = int'(c_pos);
					else
						at = int'(c_pos) + 1;
					for (int k = shadow_len; k > at; k--)
						shadow_entries[k] = shadow_entries[k-1];
					shadow_entries[at] = c_val;
					shadow_len++;
				end
			end
			OP_REMOVE: begin
				if (int'(c_pos) >= shadow_len) begin
					r.st = ST_RANGE;
				end else begin
					r.rd = shadow_entries[c_pos];
					for (int k = int'(c_pos); k + 1 < shadow_len; k++)
						shadow_entries[k] = shadow_entries[k+1];
					shadow_len--;
				end
			end
			OP_READ: begin
				if (int'(c_pos) >= shadow_len)
					r.st = ST_RANGE;
				else
					r.rd = shadow_entries[c_pos];
			end
			OP_CLEAR: begin
				shadow_len = 0;
			end
			default: begin
			end
		endcase
		r.len = LEN_W'(shadow_len);
		return r;
	endfunction

	task automatic send_cmd(input logic [2:0] c_op, input logic [POS_W-1:0] c_pos,
			input logic [DATA_W-1:0] c_val, input bit pin, input logic [DATA_W-1:0] e_rd,
			input logic [LEN_W-1:0] e_len, input status_t e_st);
		start      <= 1'b1;
		op         <= c_op;
		position   <= c_pos;
		item_value <= c_val;
		row_pin    <= pin;
		row_rd     <= e_rd;
		row_len    <= e_len;
		row_st     <= e_st;
		do
			@(posedge clk);
		while (busy);
	endtask

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				got.rd  = read_value;
				got.len = list_length;
				got.st  = status_t'(status);
				if (outcomes_due.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected result: rd=%0d len=%0d st=%0d",
							got.rd, got.len, got.st);
				end else begin
					want = outcomes_due.pop_front();
					if (got.rd !== want.rd || got.len !== want.len || got.st !== want.st) begin
						err_count++;
						if (err_count <= 10) begin
							$write("mismatch: expected rd=%0d len=%0d st=%0d, ",
								want.rd, want.len, want.st);
							$display("got rd=%0d len=%0d st=%0d",
								got.rd, got.len, got.st);
						end
					end
				end
			end
			if (start && !busy) begin
				want = list_apply(op, position, item_value);
				if (row_pin) begin
					want.rd  = row_rd;
					want.len = row_len;
					want.st  = row_st;
				end
				outcomes_due.push_back(want);
			end
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("positional_list_engine verification failed");
				$finish;
			end
			hint_len <= shadow_len;
		end
	end

	initial begin
		int                idle_pct;
		int                left_in_mode;
		int                r;
		mode_t             mode;
		logic [2:0]        c_op;
		logic [POS_W-1:0]  c_pos;
		logic [DATA_W-1:0] c_val;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i])
			send_cmd(plan[i].c_op, plan[i].c_pos, plan[i].c_val, plan[i].pin,
				plan[i].e_rd, plan[i].e_len, plan[i].e_st);
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct     = (ph == 0) ? 25 : (ph == 1) ? 75 : 0;
			mode         = MODE_FILL;
			left_in_mode = 45;
			for (int n = 0; n < RAND_ITEMS; n++) begin
				if (left_in_mode == 0) begin
					mode         = mode_t'($urandom_range(0, 2));
					left_in_mode = $urandom_range(20, 50);
				end
				left_in_mode--;
				r = $urandom_range(0, 99);
				case (mode)
					MODE_FILL:
						c_op = r < 40 ? OP_PUSH : r < 62 ? OP_INS_BEFORE : r < 85 ? OP_INS_AFTER :
							r < 93 ? OP_READ : OP_REMOVE;
					MODE_DRAIN:
						c_op = r < 75 ? OP_REMOVE : r < 88 ? OP_READ : r < 94 ? OP_PUSH :
							OP_INS_AFTER;
					default:
						c_op = r < 16 ? OP_PUSH : r < 32 ? OP_INS_BEFORE : r < 48 ? OP_INS_AFTER :
							r < 66 ? OP_REMOVE : r < 86 ? OP_READ : r < 92 ? OP_CLEAR :
							r < 96 ? OP_SPARE_A : OP_SPARE_B;
				endcase
				if ($urandom_range(0, 49) == 0)
					c_op = OP_CLEAR;
				if ($urandom_range(0, 99) < 85 && hint_len > 0)
					c_pos = POS_W'($urandom_range(0, (hint_len > CAP ? CAP : hint_len) - 1));
				else
					c_pos = POS_W'($urandom_range(0, CAP - 1));
				case ($urandom_range(0, 39))
					0: c_val = V_MIN;
					1: c_val = V_MAX;
					2: c_val = '0;
					3: c_val = V_NEG1;
					default: c_val = $urandom;
				endcase
				send_cmd(c_op, c_pos, c_val, 1'b0, '0, '0, ST_OK);
				while ($urandom_range(0, 99) < idle_pct) begin
					start <= 1'b0;
					@(posedge clk);
				end
			end
		end
		start   <= 1'b0;
		row_pin <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (err_count == 0 && outcomes_due.size() == 0)
			$display("positional_list_engine verification clean");
		else
			$display("positional_list_engine verification failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/positional_list_engine.sv
bench/tb_positional_list_engine.sv
